>>> design/hex8_shape_function_eval_assert.svh
// Assertion macros used by the node sequencer of the shape function evaluator RTL.
`ifndef HEX8_SHAPE_FUNCTION_EVAL_ASSERT_SVH
`define HEX8_SHAPE_FUNCTION_EVAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define HEX8_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("hex8 same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define HEX8_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("hex8 next-cycle check failed");
`else
`define HEX8_IMPL(lbl, clk, rstn, ante, cons)
`define HEX8_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> design/hex8_pkg.sv
// Types and constants of the hexahedron shape function evaluator.
package hex8_pkg;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned FACT_W  = 16;
	localparam int unsigned NODES   = 8;
	localparam int unsigned NODE_W  = 3;
	localparam int unsigned PROD_W  = 31;
	localparam int unsigned SHAPE_W = 15;
	localparam int unsigned DER_W   = 15;
	localparam int unsigned QDEPTH  = 2;

	typedef logic [NODE_W-1:0] node_t;
	localparam node_t LAST_NODE = 3'd7;

	// Per-node sign of each coordinate: bit k set means (1 + coord).
	localparam logic [NODES-1:0] NODE_SX = 8'b0110_0110;
	localparam logic [NODES-1:0] NODE_SY = 8'b1100_1100;
	localparam logic [NODES-1:0] NODE_SZ = 8'b1111_0000;

	// (1 - c) and (1 + c) for each coordinate, unsigned Q2.14, 0..32768.
	typedef struct packed {
		logic [FACT_W-1:0] mx;
		logic [FACT_W-1:0] px;
		logic [FACT_W-1:0] my;
		logic [FACT_W-1:0] py;
		logic [FACT_W-1:0] mz;
		logic [FACT_W-1:0] pz;
	} fact_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

>>> design/hex8_front.sv
// Front end: takes a point, clamps the coordinates and forms the six factors.
module hex8_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    xi,
	input  logic signed [15:0]    eta,
	input  logic signed [15:0]    zeta,
	input  hex8_pkg::q_stat_t     stat,
	output logic                  push,
	output hex8_pkg::fact_t       fact
);
	function automatic logic signed [16:0] clamp(logic signed [15:0] v);
		logic signed [16:0] r;
		if (v > 16'sd16384) begin
			r = 17'sd16384;
		end else if (v < -16'sd16384) begin
			r = -17'sd16384;
		end else begin
			r = {v[15], v};
		end
		return r;
	endfunction

	logic signed [16:0] cx, cy, cz;
	logic signed [16:0] mx, px, my, py, mz, pz;

	always_comb begin
		cx = clamp(xi);
		cy = clamp(eta);
		cz = clamp(zeta);
		mx = 17'sd16384 - cx;
		px = 17'sd16384 + cx;
		my = 17'sd16384 - cy;
		py = 17'sd16384 + cy;
		mz = 17'sd16384 - cz;
		pz = 17'sd16384 + cz;
		fact.mx = mx[15:0];
		fact.px = px[15:0];
		fact.my = my[15:0];
		fact.py = py[15:0];
		fact.mz = mz[15:0];
		fact.pz = pz[15:0];
	end

	assign in_ready = !stat.full;
	assign push     = in_valid && !stat.full;
endmodule

>>> design/hex8_queue.sv
// Two-entry queue of factor sets between front end and node sequencer.
module hex8_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hex8_pkg::fact_t   wdata,
	input  logic              pop,
	output hex8_pkg::fact_t   head,
	output hex8_pkg::q_stat_t stat
);
	hex8_pkg::fact_t mem_q [hex8_pkg::QDEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == 2'(hex8_pkg::QDEPTH));
	assign stat.empty = (cnt_q == 2'd0);
endmodule

>>> design/hex8_back.sv
// Node sequencer: walks the eight nodes of the head point through a multiply pipeline.
`include "hex8_shape_function_eval_assert.svh"
module hex8_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hex8_pkg::fact_t       head,
	input  hex8_pkg::q_stat_t     stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            node_index,
	output logic [14:0]           shape_value,
	output logic signed [14:0]    d_xi,
	output logic signed [14:0]    d_eta,
	output logic signed [14:0]    d_zeta,
	output logic                  last_node
);
	localparam int unsigned FW = hex8_pkg::FACT_W;
	localparam int unsigned PW = hex8_pkg::PROD_W;
	localparam int unsigned SW = PW + FW;

	function automatic logic [hex8_pkg::DER_W-1:0] deriv(logic [PW-1:0] p, logic plus);
		logic [PW-1:0]               r;
		logic [hex8_pkg::DER_W-1:0] mag;
		r   = p + 31'h0001_0000;
		mag = {1'b0, r[PW-1:17]};
		return plus ? mag : (15'd0 - mag);
	endfunction

	logic en, issue;
	logic out_hold;
	hex8_pkg::node_t k_q;

	logic            v_s1;
	hex8_pkg::node_t k_s1;
	logic [FW-1:0]   fx_s1, fy_s1, fz_s1;

	logic            v_s2;
	hex8_pkg::node_t k_s2;
	logic [FW-1:0]   fz_s2;
	logic [PW-1:0]   pxy_s2, pxz_s2, pyz_s2;

	logic                       v_s3;
	hex8_pkg::node_t            k_s3;
	logic [hex8_pkg::SHAPE_W-1:0] shape_s3;
	logic [hex8_pkg::DER_W-1:0]   dx_s3, dy_s3, dz_s3;

	logic [SW-1:0] shape_p;
	logic [SW-1:0] shape_r;

	// Whole pipeline advances only when the output register can take a beat.
	assign en    = !v_s3 || out_ready;
	assign issue = en && !stat.empty;
	assign pop   = issue && (k_q == hex8_pkg::LAST_NODE);

	always_comb begin
		shape_p = SW'(pxy_s2) * SW'(fz_s2);
		shape_r = shape_p + (SW'(1) << 30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			if (issue) begin
				k_q <= k_q + 3'd1;
			end
			v_s1 <= !stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1  <= k_q;
			fx_s1 <= hex8_pkg::NODE_SX[k_q] ? head.px : head.mx;
			fy_s1 <= hex8_pkg::NODE_SY[k_q] ? head.py : head.my;
			fz_s1 <= hex8_pkg::NODE_SZ[k_q] ? head.pz : head.mz;

			k_s2   <= k_s1;
			fz_s2  <= fz_s1;
			pxy_s2 <= PW'(fx_s1) * PW'(fy_s1);
			pxz_s2 <= PW'(fx_s1) * PW'(fz_s1);
			pyz_s2 <= PW'(fy_s1) * PW'(fz_s1);

			k_s3     <= k_s2;
			shape_s3 <= shape_r[SW-2:31];
			dx_s3    <= deriv(pyz_s2, hex8_pkg::NODE_SX[k_s2]);
			dy_s3    <= deriv(pxz_s2, hex8_pkg::NODE_SY[k_s2]);
			dz_s3    <= deriv(pxy_s2, hex8_pkg::NODE_SZ[k_s2]);
		end
	end

	assign out_valid   = v_s3;
	assign node_index  = k_s3;
	assign shape_value = shape_s3;
	assign d_xi        = $signed(dx_s3);
	assign d_eta       = $signed(dy_s3);
	assign d_zeta      = $signed(dz_s3);
	assign last_node   = (k_s3 == hex8_pkg::LAST_NODE);
	assign out_hold    = out_valid && !out_ready;

	`HEX8_IMPL(a_shape_range, clk, arst_n, out_valid, shape_value <= 15'd16384)
	`HEX8_IMPL(a_dxi_range, clk, arst_n, out_valid, (d_xi >= -15'sd8192) && (d_xi <= 15'sd8192))
	`HEX8_IMPL(a_dzeta_range, clk, arst_n, out_valid, (d_zeta >= -15'sd8192) && (d_zeta <= 15'sd8192))
	`HEX8_NEXT(a_stall_hold, clk, arst_n, out_hold, out_valid && $stable({node_index, shape_value}))
endmodule

>>> design/hex8_shape_function_eval.sv
// Trilinear hexahedron shape function evaluator, top level.
// Input channel (in_valid/in_ready): one point xi, eta, zeta in signed Q1.14;
// coordinates beyond [-1, 1] are clamped. Output channel (out_valid/out_ready):
// eight beats per point, node_index 0..7 in standard order, each with the shape
// value in Q1.14 and its three partial derivatives in signed Q0.14; last_node marks node 7.
// The first beat of a point passes the sequencer stages s1, s2 and s3 after the point
// is accepted, provided the sequencer is free. Throughput: one beat per cycle while
// the receiver takes each beat, set by the node sequencer stepping through the 8 nodes of
// one point over a single shared multiply pipeline.
// A two-entry queue sits between the front end and the sequencer, so new points
// are taken while earlier ones are still being expanded; in_ready drops only
// when that queue is full.
// When the receiver stalls, the whole sequencer pipeline holds and the output
// beat stays unchanged until taken. Reset (arst_n low) empties the queue and
// the pipeline; no beat is pending afterwards.
module hex8_shape_function_eval (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    xi,
	input  logic signed [15:0]    eta,
	input  logic signed [15:0]    zeta,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            node_index,
	output logic [14:0]           shape_value,
	output logic signed [14:0]    d_xi,
	output logic signed [14:0]    d_eta,
	output logic signed [14:0]    d_zeta,
	output logic                  last_node
);
	hex8_pkg::q_stat_t stat;
	hex8_pkg::fact_t   fact;
	hex8_pkg::fact_t   head;
	logic              push;
	logic              pop;

	hex8_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.xi       (xi),
		.eta      (eta),
		.zeta     (zeta),
		.stat     (stat),
		.push     (push),
		.fact     (fact)
	);

	hex8_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fact),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	hex8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.node_index  (node_index),
		.shape_value (shape_value),
		.d_xi        (d_xi),
		.d_eta       (d_eta),
		.d_zeta      (d_zeta),
		.last_node   (last_node)
	);
endmodule

>>> tb/tb.sv
// Self-checking testbench for the hex8 shape function evaluator.
`timescale 1ns / 1ps

module tb;
	localparam int Q_ONE   = 16384;
	localparam int LIMIT   = 200000;
	localparam int SETTLE  = 16;
	localparam int HOLD_OFF = 400;
	// Node sign masks: bit k set means the node takes (1 + coord).
	localparam logic [7:0] SIGN_X = 8'b0110_0110;
	localparam logic [7:0] SIGN_Y = 8'b1100_1100;
	localparam logic [7:0] SIGN_Z = 8'b1111_0000;

	typedef struct {
		logic signed [15:0] xi;
		logic signed [15:0] eta;
		logic signed [15:0] zeta;
	} point_t;

	typedef struct {
		logic [2:0]  node;
		logic [14:0] shape;
		logic [14:0] dxi;
		logic [14:0] deta;
		logic [14:0] dzeta;
		logic        last;
	} node_beat_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] xi;
	logic signed [15:0] eta;
	logic signed [15:0] zeta;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         node_index;
	logic [14:0]        shape_value;
	logic signed [14:0] d_xi;
	logic signed [14:0] d_eta;
	logic signed [14:0] d_zeta;
	logic               last_node;

	point_t     point_q[$];
	node_beat_t node_beat_q[$];
	point_t     next_point;
	node_beat_t want;
	int         n_queued;
	int         n_accepted;
	int         mismatches;
	int         cycles;
	int         send_idle;
	int         recv_idle;
	int         hold_left;
	logic       in_taken;

	hex8_shape_function_eval i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.xi          (xi),
		.eta         (eta),
		.zeta        (zeta),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.node_index  (node_index),
		.shape_value (shape_value),
		.d_xi        (d_xi),
		.d_eta       (d_eta),
		.d_zeta      (d_zeta),
		.last_node   (last_node)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int clamp_coord(logic signed [15:0] c);
		int v;
		v = c;
		if (v > Q_ONE)
			v = Q_ONE;
		if (v < -Q_ONE)
			v = -Q_ONE;
		return v;
	endfunction

	// Round the magnitude half up, then apply the sign (ties go away from zero).
	function automatic logic [14:0] round_partial(longint unsigned a, longint unsigned b,
			logic plus);
		longint unsigned mag;
		mag = (a * b + 64'd65536) >> 17;
		if (!plus)
			mag = -mag;
		return mag[14:0];
	endfunction

	task automatic expand_point(point_t p);
		int              x, y, z;
		longint unsigned fx, fy, fz, prod;
		node_beat_t      r;
		x = clamp_coord(p.xi);
		y = clamp_coord(p.eta);
		z = clamp_coord(p.zeta);
		for (int k = 0; k < 8; k++) begin
			fx = SIGN_X[k] ? (Q_ONE + x) : (Q_ONE - x);
			fy = SIGN_Y[k] ? (Q_ONE + y) : (Q_ONE - y);
			fz = SIGN_Z[k] ? (Q_ONE + z) : (Q_ONE - z);
			prod = fx * fy * fz;
			r.node  = 3'(k);
			r.shape = 15'((prod + (64'd1 << 30)) >> 31);
			r.dxi   = round_partial(fy, fz, SIGN_X[k]);
			r.deta  = round_partial(fx, fz, SIGN_Y[k]);
			r.dzeta = round_partial(fx, fy, SIGN_Z[k]);
			r.last  = (k == 7);
			node_beat_q.push_back(r);
		end
	endtask

	function automatic logic signed [15:0] rand_coord();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 16'($urandom);
		if (sel == 1) begin
			case ($urandom_range(4))
				0: return -16'sd16384;
				1: return 16'sd16384;
				2: return -16'sd16383;
				3: return 16'sd16383;
				default: return 16'sd0;
			endcase
		end
		return 16'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
	endfunction

	task automatic add_point(int x, int y, int z);
		point_t p;
		p.xi   = 16'(x);
		p.eta  = 16'(y);
		p.zeta = 16'(z);
		point_q.push_back(p);
		n_queued++;
	endtask

	task automatic add_random(int count);
		for (int i = 0; i < count; i++)
			add_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || node_beat_q.size() != 0)
			@(negedge clk);
	endtask

	// Sender: change the beat only at the falling edge, hold it until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (point_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				next_point = point_q.pop_front();
				in_valid   <= 1'b1;
				xi         <= next_point.xi;
				eta        <= next_point.eta;
				zeta       <= next_point.zeta;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				next_point.xi   = xi;
				next_point.eta  = eta;
				next_point.zeta = zeta;
				expand_point(next_point);
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				if (node_beat_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: node %0d shape %0d", node_index, shape_value);
				end else begin
					want = node_beat_q.pop_front();
					if (node_index !== want.node || shape_value !== want.shape ||
							d_xi !== want.dxi || d_eta !== want.deta ||
							d_zeta !== want.dzeta || last_node !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp node %0d shape %0d d %0d %0d %0d last %0d",
								want.node, want.shape, $signed(want.dxi),
								$signed(want.deta), $signed(want.dzeta), want.last);
							$display("          got node %0d shape %0d d %0d %0d %0d last %0d",
								node_index, shape_value, d_xi, d_eta, d_zeta, last_node);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[hex8_shape_function_eval] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		out_ready  = 1'b0;
		xi         = '0;
		eta        = '0;
		zeta       = '0;
		in_taken   = 1'b0;
		n_queued   = 0;
		n_accepted = 0;
		mismatches = 0;
		cycles     = 0;
		hold_left  = 0;
		send_idle  = 37;
		recv_idle  = 71;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Center, all eight corners, clamped coordinates and rounding ties.
		add_point(0, 0, 0);
		for (int c = 0; c < 8; c++)
			add_point(c[0] ? Q_ONE : -Q_ONE, c[1] ? Q_ONE : -Q_ONE, c[2] ? Q_ONE : -Q_ONE);
		add_point(32767, -32768, 16385);
		add_point(-16385, 32767, -32768);
		add_point(16383, -16383, 1);
		add_point(-1, 1, -1);
		add_point(0, -16128, -16128);
		add_point(16128, 16128, 16128);
		add_point(-15360, -15360, -15360);
		add_point(15360, -15360, 15360);
		wait_drained();

		add_random(65);
		wait_drained();

		// Stall the output long enough to back up the input.
		send_idle = 0;
		recv_idle = 0;
		@(posedge clk);
		hold_left = HOLD_OFF;
		add_random(20);
		wait_drained();

		send_idle = 71;
		recv_idle = 37;
		add_random(65);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		add_random(55);
		wait_drained();

		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("[hex8_shape_function_eval] OK");
		else
			$display("[hex8_shape_function_eval] ERROR");
		$finish;
	end
endmodule
